// File: rtl/qfts_pkg.sv
// ----------------------------------------------------------------------------
// Queue from two stacks: shared definitions
// Sizes, command codes, status codes and the output sign extension.
// ----------------------------------------------------------------------------
package qfts_pkg;

    localparam int STACK_DEPTH = 8;
    localparam int DATA_WIDTH  = 32;
    localparam int OUT_WIDTH   = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    function automatic logic [OUT_WIDTH-1:0] widen(input logic [DATA_WIDTH-1:0] v);
        logic signed [DATA_WIDTH-1:0] s;
        logic signed [63:0]           w;
        s = v;
        w = 64'(s);
        return w[OUT_WIDTH-1:0];
    endfunction

endpackage

// File: rtl/qfts_ram.sv
// ----------------------------------------------------------------------------
// Queue from two stacks: stack storage
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module qfts_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/queue_from_two_stacks.sv
// Sequence: an enqueue with room passes through S_PUSH and S_DONE; a dequeue from a non-empty
// output stack passes through S_DEQ_RD, S_DEQ_WAIT and S_DONE; a refused request goes straight
// to S_DONE. A transfer between the stacks passes through S_XFER_RD and S_XFER_WR for each
// moved element, as the registered read of the input stack feeds the output stack.
// One request is in work at a time; a stalled result holds the sequencer until it is taken.
// Reset (synchronous, active low) empties both stacks; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Queue from two stacks
// A first-in first-out queue built from an input stack and an output stack,
// with a small sequencer that moves elements across one at a time.
// ----------------------------------------------------------------------------
module queue_from_two_stacks
    import qfts_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_command,
    input  logic signed [31:0]          i_value_in,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [OUT_WIDTH-1:0] o_value_out,
    output logic [1:0]                  o_status,
    output logic                        o_now_empty
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_XFER_RD,
        S_XFER_WR,
        S_PUSH,
        S_DEQ_RD,
        S_DEQ_WAIT,
        S_DONE
    } t_state;

    t_state                r_state;
    logic                  r_cmd;
    logic [DATA_WIDTH-1:0] r_val;
    logic [CNT_W-1:0]      r_in_cnt;
    logic [CNT_W-1:0]      r_out_cnt;
    logic [OUT_WIDTH-1:0]  r_res_val;
    t_status               r_res_st;
    logic                  r_o_valid;
    logic [OUT_WIDTH-1:0]  r_o_value;
    logic [1:0]            r_o_status;
    logic                  r_o_empty;

    logic                  accept;
    logic                  out_free;
    logic                  in_full;
    logic [CNT_W-1:0]      in_top;
    logic [CNT_W-1:0]      out_top;

    logic                  in_we;
    logic [ADDR_W-1:0]     in_waddr;
    logic [ADDR_W-1:0]     in_raddr;
    logic [DATA_WIDTH-1:0] in_rdata;
    logic                  out_we;
    logic [ADDR_W-1:0]     out_waddr;
    logic [ADDR_W-1:0]     out_raddr;
    logic [DATA_WIDTH-1:0] out_rdata;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;
    assign in_full  = (r_in_cnt == CNT_W'(STACK_DEPTH));
    assign in_top   = r_in_cnt - CNT_W'(1);
    assign out_top  = r_out_cnt - CNT_W'(1);

    assign in_we     = (r_state == S_PUSH);
    assign in_waddr  = r_in_cnt[ADDR_W-1:0];
    assign in_raddr  = in_top[ADDR_W-1:0];
    assign out_we    = (r_state == S_XFER_WR);
    assign out_waddr = r_out_cnt[ADDR_W-1:0];
    assign out_raddr = out_top[ADDR_W-1:0];

    qfts_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_in_stack (
        .i_clk   (i_clk),
        .i_we    (in_we),
        .i_waddr (in_waddr),
        .i_wdata (r_val),
        .i_raddr (in_raddr),
        .o_rdata (in_rdata)
    );

    qfts_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_out_stack (
        .i_clk   (i_clk),
        .i_we    (out_we),
        .i_waddr (out_waddr),
        .i_wdata (in_rdata),
        .i_raddr (out_raddr),
        .o_rdata (out_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_cnt   <= '0;
            r_out_cnt  <= '0;
            r_o_valid  <= 1'b0;
            r_cmd      <= CMD_ENQ;
            r_val      <= '0;
            r_res_val  <= '0;
            r_res_st   <= ST_OK;
            r_o_value  <= '0;
            r_o_status <= '0;
            r_o_empty  <= 1'b1;
        end else begin
            if (r_o_valid && !i_stall && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd     <= i_command;
                        r_val     <= i_value_in[DATA_WIDTH-1:0];
                        r_res_val <= '0;
                        r_res_st  <= ST_OK;
                        if (i_command == CMD_ENQ) begin
                            if (!in_full) begin
                                r_state <= S_PUSH;
                            end else if (r_out_cnt != '0) begin
                                r_res_st <= ST_FULL;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_XFER_RD;
                            end
                        end else begin
                            if (r_out_cnt != '0) begin
                                r_state <= S_DEQ_RD;
                            end else if (r_in_cnt == '0) begin
                                r_res_st <= ST_EMPTY;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_XFER_RD;
                            end
                        end
                    end
                end
                S_XFER_RD: begin
                    r_in_cnt <= in_top;
                    r_state  <= S_XFER_WR;
                end
                S_XFER_WR: begin
                    r_out_cnt <= r_out_cnt + CNT_W'(1);
                    if (r_in_cnt != '0) begin
                        r_state <= S_XFER_RD;
                    end else if (r_cmd == CMD_DEQ) begin
                        r_state <= S_DEQ_RD;
                    end else begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    r_in_cnt <= r_in_cnt + CNT_W'(1);
                    r_state  <= S_DONE;
                end
                S_DEQ_RD: begin
                    r_out_cnt <= out_top;
                    r_state   <= S_DEQ_WAIT;
                end
                S_DEQ_WAIT: begin
                    r_res_val <= widen(out_rdata);
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_value  <= r_res_val;
                        r_o_status <= r_res_st;
                        r_o_empty  <= (r_in_cnt == '0) && (r_out_cnt == '0);
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_o_valid;
    assign o_value_out = r_o_value;
    assign o_status    = r_o_status;
    assign o_now_empty = r_o_empty;

endmodule

// File: verif/tb_queue_from_two_stacks.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the queue built from two stacks
// Sends enqueue and dequeue requests through the valid/stall handshake and
// keeps its own copy of both stacks to predict the value, status and empty
// flag of every result. Both sides pause and stall at random between requests.
// ----------------------------------------------------------------------------
module tb_queue_from_two_stacks
    import qfts_pkg::*;
();

    typedef struct {
        logic signed [31:0] value;
        t_status            status;
        logic               empty;
    } t_outcome;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic                        i_command;
    logic signed [31:0]          i_value_in;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic signed [OUT_WIDTH-1:0] o_value_out;
    logic [1:0]                  o_status;
    logic                        o_now_empty;

    t_outcome              outcome_fifo [$];
    logic [DATA_WIDTH-1:0] in_stk [STACK_DEPTH];
    logic [DATA_WIDTH-1:0] out_stk [STACK_DEPTH];
    int                    in_cnt;
    int                    out_cnt;
    int                    mismatch_count;
    int                    stall_left;
    bit                    send_idle_on;
    bit                    recv_idle_on;

    queue_from_two_stacks dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_command   (i_command),
        .i_value_in  (i_value_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_value_out (o_value_out),
        .o_status    (o_status),
        .o_now_empty (o_now_empty)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic void shift_across();
        while (in_cnt > 0 && out_cnt < STACK_DEPTH) begin
            in_cnt--;
            out_stk[out_cnt] = in_stk[in_cnt];
            out_cnt++;
        end
    endfunction

    function automatic t_outcome apply_queue_op(logic cmd, logic signed [31:0] val);
        t_outcome                     r;
        logic signed [DATA_WIDTH-1:0] s;
        logic signed [63:0]           w;
        r.value  = '0;
        r.status = ST_OK;
        if (cmd == CMD_ENQ) begin
            if (in_cnt >= STACK_DEPTH) begin
                if (out_cnt > 0) begin
                    r.status = ST_FULL;
                end else begin
                    shift_across();
                end
            end
            if (r.status == ST_OK && in_cnt < STACK_DEPTH) begin
                in_stk[in_cnt] = DATA_WIDTH'(val);
                in_cnt++;
            end
        end else begin
            if (out_cnt == 0) begin
                if (in_cnt == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    shift_across();
                end
            end
            if (r.status == ST_OK && out_cnt > 0) begin
                out_cnt--;
                s = out_stk[out_cnt];
                w = s;
                r.value = w[31:0];
            end
        end
        r.empty = (in_cnt == 0 && out_cnt == 0);
        return r;
    endfunction

    function automatic void flag_error(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t ns: %s", $time, msg);
        end
    endfunction

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -32'sd1;
            3: return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(logic cmd, logic signed [31:0] val);
        int gap;
        gap = send_idle_on ? $urandom_range(0, 19) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    = 1'b1;
        i_command  = cmd;
        i_value_in = val;
        do @(posedge i_clk); while (o_stall);
        outcome_fifo.push_back(apply_queue_op(cmd, val));
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (outcome_fifo.size() != 0) @(posedge i_clk);
    endtask

    // Covers the empty dequeue, a transfer on dequeue, a full refusal and a
    // transfer on enqueue, with the corner values of the data word.
    task automatic test_directed();
        logic signed [31:0] corner [8] = '{32'sh8000_0000, 32'sh7fff_ffff, -32'sd1, 32'sd0,
                                           32'sh5555_5555, 32'shaaaa_aaaa, 32'sd1,
                                           32'sh8000_0001};
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        send_request(CMD_DEQ, $urandom);
        for (int i = 0; i < 4; i++) send_request(CMD_ENQ, corner[i]);
        send_request(CMD_DEQ, $urandom);
        for (int i = 0; i < STACK_DEPTH; i++) send_request(CMD_ENQ, corner[i]);
        send_request(CMD_ENQ, $urandom);
        for (int i = 0; i < 3; i++) send_request(CMD_DEQ, $urandom);
        send_request(CMD_ENQ, corner[4]);
        wait_for_results();
    endtask

    task automatic test_burst_traffic(int n);
        int   sent;
        int   len;
        logic cmd;
        sent = 0;
        while (sent < n) begin
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            cmd = $urandom_range(0, 1) ? CMD_DEQ : CMD_ENQ;
            len = $urandom_range(1, 18);
            for (int i = 0; i < len; i++) send_request(cmd, rand_word());
            sent += len;
        end
        wait_for_results();
    endtask

    task automatic test_random_noise(int n);
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        for (int i = 0; i < n; i++) begin
            send_request($urandom_range(0, 1) ? CMD_DEQ : CMD_ENQ, $urandom);
        end
        wait_for_results();
    endtask

    task automatic test_back_to_back(int n);
        int   sent;
        int   len;
        logic cmd;
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        sent = 0;
        while (sent < n) begin
            cmd = $urandom_range(0, 1) ? CMD_DEQ : CMD_ENQ;
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) send_request(cmd, rand_word());
            sent += len;
        end
        wait_for_results();
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall = 1'b1;
            stall_left--;
        end else begin
            i_stall = 1'b0;
        end
    end

    initial begin : result_checker
        t_outcome want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (outcome_fifo.size() == 0) begin
                    flag_error($sformatf("result with no request pending: value %0d status %0d",
                                         o_value_out, o_status));
                end else begin
                    want = outcome_fifo.pop_front();
                    if (o_value_out !== want.value) begin
                        flag_error($sformatf("value_out expected %0d got %0d",
                                             want.value, o_value_out));
                    end
                    if (o_status !== want.status) begin
                        flag_error($sformatf("status expected %0d got %0d",
                                             want.status, o_status));
                    end
                    if (o_now_empty !== want.empty) begin
                        flag_error($sformatf("now_empty expected %0d got %0d",
                                             want.empty, o_now_empty));
                    end
                end
                stall_left = recv_idle_on ? $urandom_range(0, 19) : 0;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_command      = CMD_ENQ;
        i_value_in     = '0;
        in_cnt         = 0;
        out_cnt        = 0;
        mismatch_count = 0;
        stall_left     = 0;
        send_idle_on   = 1'b1;
        recv_idle_on   = 1'b1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_burst_traffic(650);
        test_random_noise(250);
        test_back_to_back(100);

        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0 && outcome_fifo.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
